// ===== rtl/core/alt_pkg.sv =====
// Package: sizes, codes and shared types of the adjacency list table.
`timescale 1ns / 1ps
package alt_pkg;

    // Table geometry
    localparam int MAX_ROWS   = 64;
    localparam int MAX_DEGREE = 16;
    localparam int MAX_COLS   = 1024;

    // Field widths
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int LEN_W    = $clog2(MAX_DEGREE + 1);
    localparam int SLOT_W   = $clog2(MAX_DEGREE);
    localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_DEGREE);
    localparam int SWEEP_W  = $clog2(MAX_ROWS + 1);
    localparam int ROWCNT_W = 7;
    localparam int COLCNT_W = 11;
    localparam int EDGE_W   = 11;
    localparam int REQ_W    = 3;
    localparam int STAT_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = COLCNT_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'd1;
    localparam logic [ROWCNT_W-1:0]  ROW_COUNT_RST = ROWCNT_W'(64);
    localparam logic [COLCNT_W-1:0]  COL_COUNT_RST = COLCNT_W'(1024);

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD    = 3'd0,
        REQ_DEL    = 3'd1,
        REQ_CONN   = 3'd2,
        REQ_DEGREE = 3'd3,
        REQ_MAXDEG = 3'd4,
        REQ_LIST   = 3'd5
    } t_req_type;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_SCAN,
        S_DECIDE,
        S_LDATA,
        S_MAXD,
        S_EMIT
    } t_state;

    // Effective configuration
    typedef struct packed {
        logic [ROWCNT_W-1:0] rows;
        logic [COLCNT_W-1:0] cols;
    } t_cfg;

    // Result word
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [COL_W-1:0]  neighbor;
        logic [LEN_W-1:0]  degree;
        logic [LEN_W-1:0]  max_degree;
        logic [EDGE_W-1:0] edge_count;
        logic              last;
    } t_rsp;

    // Row length memory ports
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
        logic [LEN_W-1:0] data;
    } t_len_wr;

    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] addr;
    } t_len_rd;

    // Neighbor memory ports
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  data;
    } t_nbr_wr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_nbr_rd;

    // Flat neighbor address of one slot of one row
    function automatic logic [ADDR_W-1:0] nbr_addr(input logic [ROW_W-1:0] row,
                                                   input logic [SLOT_W-1:0] slot);
        nbr_addr = ADDR_W'(row) * ADDR_W'(MAX_DEGREE) + ADDR_W'(slot);
    endfunction

endpackage

// ===== rtl/core/alt_req_if.sv =====
// Interface: request channel (valid, ready and request word).
`timescale 1ns / 1ps
interface alt_req_if;
    logic                       valid;
    logic                       ready;
    logic [alt_pkg::REQ_W-1:0]  req_type;
    logic [alt_pkg::ROW_W-1:0]  row;
    logic [alt_pkg::COL_W-1:0]  col;

    modport source (output valid, output req_type, output row, output col, input ready);
    modport sink   (input valid, input req_type, input row, input col, output ready);
endinterface

// ===== rtl/core/alt_rsp_if.sv =====
// Interface: result channel (valid, ready and result word).
`timescale 1ns / 1ps
interface alt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [alt_pkg::STAT_W-1:0]  status;
    logic                        found;
    logic [alt_pkg::COL_W-1:0]   neighbor;
    logic [alt_pkg::LEN_W-1:0]   degree;
    logic [alt_pkg::LEN_W-1:0]   max_degree;
    logic [alt_pkg::EDGE_W-1:0]  edge_count;
    logic                        last;

    modport source (output valid, output status, output found, output neighbor,
                    output degree, output max_degree, output edge_count, output last,
                    input ready);
    modport sink   (input valid, input status, input found, input neighbor,
                    input degree, input max_degree, input edge_count, input last,
                    output ready);
endinterface

// ===== rtl/core/alt_len_mem.sv =====
// Row length memory: one length per row, reads as zero until first written.
`timescale 1ns / 1ps
module alt_len_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  alt_pkg::t_len_wr           i_wr,
    input  alt_pkg::t_len_rd           i_rd,
    output logic [alt_pkg::LEN_W-1:0]  o_rdata
);

    logic [alt_pkg::LEN_W-1:0]    r_mem [alt_pkg::MAX_ROWS];
    logic [alt_pkg::MAX_ROWS-1:0] r_vld;
    logic [alt_pkg::LEN_W-1:0]    r_rdata;
    logic                         r_rd_vld;

    // Written-row flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // Storage and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata  <= r_mem[i_rd.addr];
            r_rd_vld <= r_vld[i_rd.addr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

// ===== rtl/core/alt_nbr_ram.sv =====
// Neighbor memory: column indices, row-major, one read and one write port.
`timescale 1ns / 1ps
module alt_nbr_ram (
    input  logic                       i_clk,
    input  alt_pkg::t_nbr_wr           i_wr,
    input  alt_pkg::t_nbr_rd           i_rd,
    output logic [alt_pkg::COL_W-1:0]  o_rdata
);

    localparam int DEPTH = alt_pkg::MAX_ROWS * alt_pkg::MAX_DEGREE;

    logic [alt_pkg::COL_W-1:0] r_mem [DEPTH];
    logic [alt_pkg::COL_W-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rdata <= r_mem[i_rd.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/alt_ctrl.sv =====
// Sequencer: decodes a request, scans and updates the memories, drives results.
`timescale 1ns / 1ps
module alt_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  alt_pkg::t_cfg              i_cfg,
    alt_req_if.sink                    i_req,
    alt_rsp_if.source                  o_rsp,
    output alt_pkg::t_len_wr           o_len_wr,
    output alt_pkg::t_len_rd           o_len_rd,
    input  logic [alt_pkg::LEN_W-1:0]  i_len_rdata,
    output alt_pkg::t_nbr_wr           o_nbr_wr,
    output alt_pkg::t_nbr_rd           o_nbr_rd,
    input  logic [alt_pkg::COL_W-1:0]  i_nbr_rdata
);

    alt_pkg::t_state                   r_state, n_state;
    alt_pkg::t_req_type                r_req, n_req;
    logic [alt_pkg::ROW_W-1:0]         r_row, n_row;
    logic [alt_pkg::COL_W-1:0]         r_col, n_col;
    logic [alt_pkg::LEN_W-1:0]         r_len, n_len;
    logic [alt_pkg::SWEEP_W-1:0]       r_k, n_k;
    logic                              r_pend, n_pend;
    logic [alt_pkg::SLOT_W-1:0]        r_pend_k, n_pend_k;
    logic                              r_found, n_found;
    logic [alt_pkg::SLOT_W-1:0]        r_pos, n_pos;
    logic [alt_pkg::COL_W-1:0]         r_last_val, n_last_val;
    logic [alt_pkg::LEN_W-1:0]         r_best, n_best;
    logic [alt_pkg::EDGE_W-1:0]        r_edges, n_edges;
    logic [alt_pkg::STAT_W-1:0]        r_res_status, n_res_status;
    logic                              r_res_found, n_res_found;
    logic [alt_pkg::LEN_W-1:0]         r_res_deg, n_res_deg;
    logic [alt_pkg::LEN_W-1:0]         r_res_maxd, n_res_maxd;
    logic                              r_out_valid, n_out_valid;
    alt_pkg::t_rsp                     r_out, n_out;

    logic                              out_free;
    logic                              accept;
    logic [alt_pkg::SWEEP_W-1:0]       k_next;
    logic [alt_pkg::SWEEP_W-1:0]       len_ext;

    assign out_free = !r_out_valid || o_rsp.ready;
    assign accept   = i_req.valid && i_req.ready;
    assign k_next   = r_k + alt_pkg::SWEEP_W'(1);
    assign len_ext  = alt_pkg::SWEEP_W'(r_len);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alt_pkg::S_IDLE;
            r_edges     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_edges     <= n_edges;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_row        <= n_row;
        r_col        <= n_col;
        r_len        <= n_len;
        r_k          <= n_k;
        r_pend_k     <= n_pend_k;
        r_found      <= n_found;
        r_pos        <= n_pos;
        r_last_val   <= n_last_val;
        r_best       <= n_best;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_deg    <= n_res_deg;
        r_res_maxd   <= n_res_maxd;
        r_out        <= n_out;
    end

    // Next state, memory accesses and result word
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_row        = r_row;
        n_col        = r_col;
        n_len        = r_len;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pend_k     = r_pend_k;
        n_found      = r_found;
        n_pos        = r_pos;
        n_last_val   = r_last_val;
        n_best       = r_best;
        n_edges      = r_edges;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_deg    = r_res_deg;
        n_res_maxd   = r_res_maxd;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        o_len_wr     = '0;
        o_len_rd     = '0;
        o_nbr_wr     = '0;
        o_nbr_rd     = '0;
        i_req.ready  = 1'b0;

        unique case (r_state)
            alt_pkg::S_IDLE: begin
                i_req.ready  = 1'b1;
                n_found      = 1'b0;
                n_k          = '0;
                n_pend       = 1'b0;
                n_best       = '0;
                n_res_found  = 1'b0;
                n_res_deg    = '0;
                n_res_maxd   = '0;
                n_res_status = alt_pkg::ST_RANGE;
                n_row        = i_req.row;
                n_col        = i_req.col;
                n_req        = alt_pkg::t_req_type'(i_req.req_type);
                if (accept) begin
                    priority if (i_req.req_type > alt_pkg::REQ_W'(alt_pkg::REQ_LIST)) begin
                        n_state = alt_pkg::S_EMIT;
                    end else if (i_req.req_type == alt_pkg::REQ_W'(alt_pkg::REQ_MAXDEG)) begin
                        n_state = alt_pkg::S_MAXD;
                    end else if (alt_pkg::ROWCNT_W'(i_req.row) >= i_cfg.rows) begin
                        n_state = alt_pkg::S_EMIT;
                    end else begin
                        o_len_rd.en   = 1'b1;
                        o_len_rd.addr = i_req.row;
                        n_state       = alt_pkg::S_LEN;
                    end
                end
            end

            alt_pkg::S_LEN: begin
                n_len        = i_len_rdata;
                n_res_status = alt_pkg::ST_DONE;
                n_res_deg    = i_len_rdata;
                unique case (r_req)
                    alt_pkg::REQ_DEGREE: begin
                        n_state = alt_pkg::S_EMIT;
                    end
                    alt_pkg::REQ_LIST: begin
                        if (i_len_rdata == '0) begin
                            n_state = alt_pkg::S_EMIT;
                        end else begin
                            o_nbr_rd.en   = 1'b1;
                            o_nbr_rd.addr = alt_pkg::nbr_addr(r_row, '0);
                            n_state       = alt_pkg::S_LDATA;
                        end
                    end
                    alt_pkg::REQ_ADD, alt_pkg::REQ_DEL, alt_pkg::REQ_CONN: begin
                        if (alt_pkg::COLCNT_W'(r_col) >= i_cfg.cols) begin
                            n_res_status = alt_pkg::ST_RANGE;
                            n_state      = alt_pkg::S_EMIT;
                        end else begin
                            n_state = alt_pkg::S_SCAN;
                        end
                    end
                    default: begin
                        n_state = alt_pkg::S_EMIT;
                    end
                endcase
            end

            // One slot read issued per cycle, compared in the next cycle
            alt_pkg::S_SCAN: begin
                if (r_k < len_ext) begin
                    o_nbr_rd.en   = 1'b1;
                    o_nbr_rd.addr = alt_pkg::nbr_addr(r_row, r_k[alt_pkg::SLOT_W-1:0]);
                    n_k           = k_next;
                    n_pend        = 1'b1;
                    n_pend_k      = r_k[alt_pkg::SLOT_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (i_nbr_rdata == r_col) begin
                        n_found = 1'b1;
                        n_pos   = r_pend_k;
                    end
                    // keep the tail entry for a delete
                    if (alt_pkg::LEN_W'(r_pend_k) == r_len - alt_pkg::LEN_W'(1)) begin
                        n_last_val = i_nbr_rdata;
                    end
                end
                if (r_k == len_ext && !r_pend) begin
                    n_state = alt_pkg::S_DECIDE;
                end
            end

            alt_pkg::S_DECIDE: begin
                n_state      = alt_pkg::S_EMIT;
                n_res_status = alt_pkg::ST_DONE;
                n_res_deg    = r_len;
                unique case (r_req)
                    alt_pkg::REQ_CONN: begin
                        n_res_found = r_found;
                    end
                    alt_pkg::REQ_ADD: begin
                        priority if (r_found) begin
                            n_res_status = alt_pkg::ST_NO_CHANGE;
                        end else if (r_len >= alt_pkg::LEN_W'(alt_pkg::MAX_DEGREE)) begin
                            n_res_status = alt_pkg::ST_FULL;
                        end else begin
                            o_nbr_wr.en   = 1'b1;
                            o_nbr_wr.addr = alt_pkg::nbr_addr(r_row,
                                                r_len[alt_pkg::SLOT_W-1:0]);
                            o_nbr_wr.data = r_col;
                            o_len_wr.en   = 1'b1;
                            o_len_wr.addr = r_row;
                            o_len_wr.data = r_len + alt_pkg::LEN_W'(1);
                            n_res_deg     = r_len + alt_pkg::LEN_W'(1);
                            n_edges       = r_edges + alt_pkg::EDGE_W'(1);
                        end
                    end
                    alt_pkg::REQ_DEL: begin
                        if (!r_found) begin
                            n_res_status = alt_pkg::ST_NO_CHANGE;
                        end else begin
                            // tail entry moves into the freed slot
                            o_nbr_wr.en   = 1'b1;
                            o_nbr_wr.addr = alt_pkg::nbr_addr(r_row, r_pos);
                            o_nbr_wr.data = r_last_val;
                            o_len_wr.en   = 1'b1;
                            o_len_wr.addr = r_row;
                            o_len_wr.data = r_len - alt_pkg::LEN_W'(1);
                            n_res_deg     = r_len - alt_pkg::LEN_W'(1);
                            n_edges       = r_edges - alt_pkg::EDGE_W'(1);
                        end
                    end
                    default: begin
                        n_res_status = alt_pkg::ST_RANGE;
                    end
                endcase
            end

            // Neighbor run: read data holds while the output is stalled
            alt_pkg::S_LDATA: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = alt_pkg::ST_DONE;
                    n_out.found      = 1'b0;
                    n_out.neighbor   = i_nbr_rdata;
                    n_out.degree     = r_len;
                    n_out.max_degree = '0;
                    n_out.edge_count = r_edges;
                    n_out.last       = (k_next == len_ext);
                    if (k_next == len_ext) begin
                        n_state = alt_pkg::S_IDLE;
                    end else begin
                        o_nbr_rd.en   = 1'b1;
                        o_nbr_rd.addr = alt_pkg::nbr_addr(r_row,
                                            k_next[alt_pkg::SLOT_W-1:0]);
                        n_k           = k_next;
                    end
                end
            end

            // Sweep over active rows for the largest length
            alt_pkg::S_MAXD: begin
                if (r_k < alt_pkg::SWEEP_W'(i_cfg.rows)) begin
                    o_len_rd.en   = 1'b1;
                    o_len_rd.addr = r_k[alt_pkg::ROW_W-1:0];
                    n_k           = k_next;
                    n_pend        = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && i_len_rdata > r_best) begin
                    n_best = i_len_rdata;
                end
                if (r_k == alt_pkg::SWEEP_W'(i_cfg.rows) && !r_pend) begin
                    n_res_status = alt_pkg::ST_DONE;
                    n_res_deg    = '0;
                    n_res_maxd   = r_best;
                    n_state      = alt_pkg::S_EMIT;
                end
            end

            alt_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.status     = r_res_status;
                    n_out.found      = r_res_found;
                    n_out.neighbor   = '0;
                    n_out.degree     = r_res_deg;
                    n_out.max_degree = r_res_maxd;
                    n_out.edge_count = r_edges;
                    n_out.last       = 1'b1;
                    n_state          = alt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = alt_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out.status;
    assign o_rsp.found      = r_out.found;
    assign o_rsp.neighbor   = r_out.neighbor;
    assign o_rsp.degree     = r_out.degree;
    assign o_rsp.max_degree = r_out.max_degree;
    assign o_rsp.edge_count = r_out.edge_count;
    assign o_rsp.last       = r_out.last;

endmodule

// ===== rtl/core/adjacency_list_table.sv =====
// Top level: directed graph as per-row neighbor lists, with configuration registers.
//
//  channel   dir  handshake       word
//  i_req     in   valid / ready   req_type, row, col
//  o_rsp     out  valid / ready   status, found, neighbor, degree, max_degree,
//                                 edge_count, last
//  i_cfg_*   in   write enable    register index, write data
//
// One request is worked at a time; all list state sits in two memories with registered reads.
// Degree reads the row length; add, delete, connected scan the row, one slot read
// per cycle from the neighbor memory, and then decide; list emits one word per cycle
// when o_rsp is ready; max degree sweeps the active rows of the length memory.
// Reset is synchronous and active low; no clearing pass, length memory has flags.
// A stalled o_rsp holds the current word; the block takes a request once the
// previous one has loaded its last word into the output register.
`timescale 1ns / 1ps
module adjacency_list_table (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    alt_req_if.sink                         i_req,
    alt_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [alt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [alt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [alt_pkg::ROWCNT_W-1:0] r_row_count;
    logic [alt_pkg::COLCNT_W-1:0] r_col_count;
    alt_pkg::t_cfg                cfg;
    alt_pkg::t_len_wr             len_wr;
    alt_pkg::t_len_rd             len_rd;
    logic [alt_pkg::LEN_W-1:0]    len_rdata;
    alt_pkg::t_nbr_wr             nbr_wr;
    alt_pkg::t_nbr_rd             nbr_rd;
    logic [alt_pkg::COL_W-1:0]    nbr_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= alt_pkg::ROW_COUNT_RST;
            r_col_count <= alt_pkg::COL_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                alt_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data[alt_pkg::ROWCNT_W-1:0];
                alt_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data[alt_pkg::COLCNT_W-1:0];
            endcase
        end
    end

    // Clamp to the table size
    assign cfg.rows = (r_row_count < alt_pkg::ROWCNT_W'(alt_pkg::MAX_ROWS))
                    ? r_row_count : alt_pkg::ROWCNT_W'(alt_pkg::MAX_ROWS);
    assign cfg.cols = (r_col_count < alt_pkg::COLCNT_W'(alt_pkg::MAX_COLS))
                    ? r_col_count : alt_pkg::COLCNT_W'(alt_pkg::MAX_COLS);

    alt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_len_wr    (len_wr),
        .o_len_rd    (len_rd),
        .i_len_rdata (len_rdata),
        .o_nbr_wr    (nbr_wr),
        .o_nbr_rd    (nbr_rd),
        .i_nbr_rdata (nbr_rdata)
    );

    alt_len_mem u_len_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (len_wr),
        .i_rd    (len_rd),
        .o_rdata (len_rdata)
    );

    alt_nbr_ram u_nbr_ram (
        .i_clk   (i_clk),
        .i_wr    (nbr_wr),
        .i_rd    (nbr_rd),
        .o_rdata (nbr_rdata)
    );

endmodule
